// ===== src/tpmv_pkg.sv =====
// ----------------------------------------------------------------------------
// tpmv_pkg
// Types and constants shared by the ternary packed matrix-vector multiplier.
// ----------------------------------------------------------------------------
package tpmv_pkg;

   localparam int TRITS_PER_BYTE = 4;
   localparam int ACT_W          = 16;
   localparam int CONTRIB_W      = ACT_W + 3;
   localparam int SCALE_FRAC     = 12;
   localparam int RESULT_W       = 32;

   typedef enum logic {
      CMD_ACT    = 1'b0,
      CMD_WEIGHT = 1'b1
   } tpmv_cmd_type;

   typedef enum logic [1:0] {
      TRIT_SKIP = 2'b00,
      TRIT_ADD  = 2'b01,
      TRIT_SUB  = 2'b10,
      TRIT_RSV  = 2'b11
   } tpmv_trit_type;

   typedef enum logic [1:0] {
      CSR_COLUMN_GROUPS = 2'd0,
      CSR_ROW_COUNT     = 2'd1,
      CSR_SCALE         = 2'd2,
      CSR_BIAS_ENABLE   = 2'd3
   } tpmv_csr_type;

   typedef struct packed {
      logic               cmd;
      logic [11:0]        act_index;
      logic signed [15:0] act_value;
      logic [7:0]         weight_byte;
      logic signed [15:0] bias_value;
   } tpmv_req_type;

   typedef struct packed {
      logic signed [31:0] row_result;
      logic [15:0]        row_index;
      logic               last_row;
      logic               reserved_seen;
   } tpmv_rsp_type;

   typedef struct packed {
      logic [10:0]        column_groups;
      logic [15:0]        row_count;
      logic signed [15:0] scale;
      logic               bias_enable;
   } tpmv_cfg_type;

   typedef struct packed {
      logic signed [CONTRIB_W-1:0] contrib;
      logic                        rsv;
      logic                        row_end;
      logic signed [ACT_W-1:0]     bias;
      logic [15:0]                 row_index;
      logic                        last_row;
   } tpmv_qent_type;

endpackage

// ===== src/tpmv_front.sv =====
// ----------------------------------------------------------------------------
// tpmv_front
// Accepts items, writes activations, tracks row and group position, reads
// four activations per weight byte and forms the byte's partial sum.
// ----------------------------------------------------------------------------
module tpmv_front #(
   parameter int MAX_COLUMNS = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tpmv_pkg::tpmv_req_type req_data,
   input  tpmv_pkg::tpmv_cfg_type cfg,
   output logic                   q_push,
   output tpmv_pkg::tpmv_qent_type q_wdata,
   input  logic                   q_full
);
   import tpmv_pkg::*;

   localparam int IDX_W       = $clog2(MAX_COLUMNS);
   localparam int GROUP_LIMIT = MAX_COLUMNS / TRITS_PER_BYTE;
   localparam int GP_W        = (IDX_W > 2) ? IDX_W - 2 : 1;
   localparam int CNT_W       = (GP_W + 1 > 11) ? GP_W + 1 : 11;

   logic [TRITS_PER_BYTE-1:0][ACT_W-1:0] store [GROUP_LIMIT];
   logic [TRITS_PER_BYTE-1:0][ACT_W-1:0] rd_ff;

   logic [GP_W-1:0]  gpos_ff, gpos_in;
   logic [15:0]      rpos_ff, rpos_in;
   logic             f1_vld_ff, f1_vld_in;
   logic [7:0]       f1_trits_ff;
   logic             f1_end_ff;
   logic             f1_last_ff;
   logic [15:0]      f1_row_ff;
   logic signed [ACT_W-1:0] f1_bias_ff;

   logic             accept, is_weight;
   logic [IDX_W-1:0] widx;
   logic [CNT_W-1:0] cfg_grp, grp_eff;
   logic [15:0]      rows_eff;
   logic             row_end, row_last;
   logic signed [CONTRIB_W-1:0] contrib;
   logic             rsv;

   assign req_ready = !f1_vld_ff || !q_full;
   assign accept    = req_valid && req_ready;
   assign is_weight = (tpmv_cmd_type'(req_data.cmd) == CMD_WEIGHT);
   assign widx      = IDX_W'(req_data.act_index);
   assign q_push    = f1_vld_ff && !q_full;

   always_comb begin
      cfg_grp = CNT_W'(cfg.column_groups);
      if (cfg_grp == '0) begin
         grp_eff = CNT_W'(1);
      end else if (cfg_grp > CNT_W'(GROUP_LIMIT)) begin
         grp_eff = CNT_W'(GROUP_LIMIT);
      end else begin
         grp_eff = cfg_grp;
      end
      rows_eff = (cfg.row_count == '0) ? 16'd1 : cfg.row_count;
      row_end  = (CNT_W'(gpos_ff) + CNT_W'(1)) >= grp_eff;
      row_last = ({1'b0, rpos_ff} + 17'd1) >= {1'b0, rows_eff};
   end

   always_comb begin
      gpos_in   = gpos_ff;
      rpos_in   = rpos_ff;
      f1_vld_in = f1_vld_ff;
      if (q_push) begin
         f1_vld_in = 1'b0;
      end
      if (accept) begin
         f1_vld_in = is_weight;
         if (is_weight) begin
            if (row_end) begin
               gpos_in = '0;
               rpos_in = row_last ? 16'd0 : rpos_ff + 16'd1;
            end else begin
               gpos_in = gpos_ff + GP_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gpos_ff   <= '0;
         rpos_ff   <= '0;
         f1_vld_ff <= 1'b0;
      end else begin
         gpos_ff   <= gpos_in;
         rpos_ff   <= rpos_in;
         f1_vld_ff <= f1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_weight) begin
         f1_trits_ff <= req_data.weight_byte;
         f1_end_ff   <= row_end;
         f1_last_ff  <= row_last;
         f1_row_ff   <= rpos_ff;
         f1_bias_ff  <= cfg.bias_enable ? req_data.bias_value : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !is_weight) begin
         store[widx[IDX_W-1:2]][widx[1:0]] <= req_data.act_value;
      end
      if (accept && is_weight) begin
         rd_ff <= store[gpos_ff];
      end
   end

   always_comb begin
      contrib = '0;
      rsv     = 1'b0;
      for (int t = 0; t < TRITS_PER_BYTE; t++) begin
         case (tpmv_trit_type'(f1_trits_ff[2*t +: 2]))
            TRIT_ADD:  contrib = contrib + CONTRIB_W'($signed(rd_ff[t]));
            TRIT_SUB:  contrib = contrib - CONTRIB_W'($signed(rd_ff[t]));
            TRIT_RSV:  rsv = 1'b1;
            TRIT_SKIP: ;
         endcase
      end
   end

   always_comb begin
      q_wdata.contrib   = contrib;
      q_wdata.rsv       = rsv;
      q_wdata.row_end   = f1_end_ff;
      q_wdata.bias      = f1_bias_ff;
      q_wdata.row_index = f1_row_ff;
      q_wdata.last_row  = f1_last_ff;
   end

endmodule

// ===== src/tpmv_queue.sv =====
// ----------------------------------------------------------------------------
// tpmv_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module tpmv_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  tpmv_pkg::tpmv_qent_type wdata,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_vld,
   output tpmv_pkg::tpmv_qent_type head
);
   import tpmv_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tpmv_qent_type    entry [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign head_vld = (cnt_ff != '0);
   assign head     = entry[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== src/tpmv_back.sv =====
// ----------------------------------------------------------------------------
// tpmv_back
// Accumulates byte partial sums, scales each finished row, adds bias and
// holds the row result in the output register.
// ----------------------------------------------------------------------------
module tpmv_back #(
   parameter int MAX_COLUMNS = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_vld,
   input  tpmv_pkg::tpmv_qent_type q_head,
   output logic                    q_pop,
   input  tpmv_pkg::tpmv_cfg_type  cfg,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tpmv_pkg::tpmv_rsp_type  rsp_data
);
   import tpmv_pkg::*;

   localparam int ACC_W = $clog2(MAX_COLUMNS) + ACT_W + 1;
   localparam int PROD_W = ACC_W + 16;
   localparam int SUM_W = ((PROD_W - SCALE_FRAC > RESULT_W) ? PROD_W - SCALE_FRAC
                                                            : RESULT_W) + 1;

   typedef struct packed {
      logic                    rsv;
      logic signed [ACT_W-1:0] bias;
      logic [15:0]             row_index;
      logic                    last_row;
   } tpmv_meta_type;

   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     rsv_ff, rsv_in;
   logic                     s1_vld_ff, s1_vld_in;
   logic signed [ACC_W-1:0]  s1_sum_ff;
   tpmv_meta_type            s1_meta_ff;
   logic                     s2_vld_ff, s2_vld_in;
   logic signed [PROD_W-1:0] s2_prod_ff;
   tpmv_meta_type            s2_meta_ff;
   logic                     rsp_vld_ff, rsp_vld_in;
   tpmv_rsp_type             rsp_data_ff;

   logic                     out_free, s2_free, s1_free;
   logic                     s1_load, s2_load, rsp_load;
   logic signed [ACC_W-1:0]  nsum;
   logic                     nrsv;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] shifted;
   logic signed [SUM_W-1:0]  total;

   assign out_free = !rsp_vld_ff || rsp_ready;
   assign s2_free  = !s2_vld_ff || out_free;
   assign s1_free  = !s1_vld_ff || s2_free;
   assign q_pop    = q_vld && (!q_head.row_end || s1_free);
   assign s1_load  = q_pop && q_head.row_end;
   assign s2_load  = s1_vld_ff && s2_free;
   assign rsp_load = s2_vld_ff && out_free;

   assign nsum    = acc_ff + ACC_W'(q_head.contrib);
   assign nrsv    = rsv_ff || q_head.rsv;
   assign prod    = PROD_W'(s1_sum_ff) * PROD_W'(cfg.scale);
   assign shifted = s2_prod_ff >>> SCALE_FRAC;
   assign total   = SUM_W'(shifted) + SUM_W'(s2_meta_ff.bias);

   always_comb begin
      acc_in = acc_ff;
      rsv_in = rsv_ff;
      if (q_pop) begin
         acc_in = q_head.row_end ? '0 : nsum;
         rsv_in = q_head.row_end ? 1'b0 : nrsv;
      end
      s1_vld_in  = s1_load || (s1_vld_ff && !s2_free);
      s2_vld_in  = s2_load || (s2_vld_ff && !out_free);
      rsp_vld_in = rsp_load || (rsp_vld_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         rsv_ff     <= 1'b0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         acc_ff     <= acc_in;
         rsv_ff     <= rsv_in;
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_sum_ff            <= nsum;
         s1_meta_ff.rsv       <= nrsv;
         s1_meta_ff.bias      <= q_head.bias;
         s1_meta_ff.row_index <= q_head.row_index;
         s1_meta_ff.last_row  <= q_head.last_row;
      end
      if (s2_load) begin
         s2_prod_ff <= prod;
         s2_meta_ff <= s1_meta_ff;
      end
      if (rsp_load) begin
         rsp_data_ff.row_result    <= total[RESULT_W-1:0];
         rsp_data_ff.row_index     <= s2_meta_ff.row_index;
         rsp_data_ff.last_row      <= s2_meta_ff.last_row;
         rsp_data_ff.reserved_seen <= s2_meta_ff.rsv;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/ternary_packed_matvec.sv =====
// ----------------------------------------------------------------------------
// ternary_packed_matvec
// Ternary weight matrix-vector multiply with Q8.8 activations and bias.
//
//   channel  ports                         moves
//   req      req_valid/req_ready/req_data  one activation or one weight byte
//   rsp      rsp_valid/rsp_ready/rsp_data  one row result
//   csr      csr_we/csr_index/csr_wdata    one register write, no wait
//
// One item per cycle while the queue has room, set by the single activation
// store read per weight byte (four activations in one wide row). A row
// result passes from its last byte through the front register, the queue,
// the sum and product stages and the output register to rsp_valid.
// The activation store has no reset and no clearing pass. A stalled rsp
// fills the scale stages and then the queue before req_ready drops.
// ----------------------------------------------------------------------------
module ternary_packed_matvec #(
   parameter int MAX_COLUMNS = 4096,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tpmv_pkg::tpmv_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tpmv_pkg::tpmv_rsp_type rsp_data,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_wdata
);
   import tpmv_pkg::*;

   tpmv_cfg_type  cfg_ff, cfg_in;
   tpmv_qent_type q_wdata, q_head;
   logic          q_push, q_full, q_pop, q_vld;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (tpmv_csr_type'(csr_index))
            CSR_COLUMN_GROUPS: cfg_in.column_groups = csr_wdata[10:0];
            CSR_ROW_COUNT:     cfg_in.row_count     = csr_wdata;
            CSR_SCALE:         cfg_in.scale         = csr_wdata;
            CSR_BIAS_ENABLE:   cfg_in.bias_enable   = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.column_groups <= 11'd1;
         cfg_ff.row_count     <= 16'd1;
         cfg_ff.scale         <= 16'sd4096;
         cfg_ff.bias_enable   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tpmv_front #(
      .MAX_COLUMNS(MAX_COLUMNS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .q_push   (q_push),
      .q_wdata  (q_wdata),
      .q_full   (q_full)
   );

   tpmv_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wdata   (q_wdata),
      .full    (q_full),
      .pop     (q_pop),
      .head_vld(q_vld),
      .head    (q_head)
   );

   tpmv_back #(
      .MAX_COLUMNS(MAX_COLUMNS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_vld    (q_vld),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .cfg      (cfg_ff),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue push while full");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_vld)
      else $error("queue pop while empty");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("row result valid right after reset");

   a_ready_on_empty_queue: assert property (@(posedge clock) disable iff (reset)
      !q_full |-> req_ready)
      else $error("input stalled with room in the queue");

endmodule
